// File: rtl/square_wave_channel_assert.svh
// Assertion macros shared by the square-wave channel RTL.
// Each use expects i_clk and i_rst_n in the enclosing module.
`ifndef SQUARE_WAVE_CHANNEL_ASSERT_SVH
`define SQUARE_WAVE_CHANNEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SQCH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SQCH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sqch_pkg.sv
// Types, codes and constants for the square-wave channel.
// No dependencies; imported by every module of the block.
package sqch_pkg;

    localparam int unsigned DUTY_COUNT = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [2:0] {
        ACT_REG_WRITE = 3'd0,
        ACT_TIMER     = 3'd1,
        ACT_QUARTER   = 3'd2,
        ACT_HALF      = 3'd3,
        ACT_ENABLE    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        REG_CTRL      = 2'd0,
        REG_SWEEP     = 2'd1,
        REG_PERIOD_LO = 2'd2,
        REG_PERIOD_HI = 2'd3
    } t_reg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_0  = 3'd0,
        CFG_DUTY_1  = 3'd1,
        CFG_DUTY_2  = 3'd2,
        CFG_DUTY_3  = 3'd3,
        CFG_NEGATE  = 3'd4
    } t_cfg_idx;

    localparam logic [7:0]  DUTY_0_RESET  = 8'h40;
    localparam logic [7:0]  DUTY_1_RESET  = 8'h60;
    localparam logic [7:0]  DUTY_2_RESET  = 8'h78;
    localparam logic [7:0]  DUTY_3_RESET  = 8'h9F;
    localparam logic [7:0]  WAVE_RESET    = 8'hF0;
    localparam logic [10:0] PERIOD_MIN    = 11'd8;
    localparam logic [3:0]  FULL_DECAY    = 4'd15;

    localparam logic [7:0] LEN_TABLE [32] = '{
        8'd10,  8'd254, 8'd20,  8'd2,   8'd40,  8'd4,   8'd80,  8'd6,
        8'd160, 8'd8,   8'd60,  8'd10,  8'd14,  8'd12,  8'd26,  8'd14,
        8'd12,  8'd16,  8'd24,  8'd18,  8'd48,  8'd20,  8'd96,  8'd22,
        8'd192, 8'd24,  8'd72,  8'd26,  8'd16,  8'd28,  8'd32,  8'd30
    };

    typedef struct packed {
        t_action    action;
        t_reg       reg_index;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [DUTY_COUNT-1:0][7:0] duty;
        logic                       negate_ones;
    } t_cfg;

    typedef struct packed {
        logic [10:0] period;
        logic [10:0] countdown;
        logic [7:0]  wave_shift;
        logic [1:0]  duty_select;
        logic [7:0]  length_left;
        logic        length_halt;
        logic        fixed_volume_mode;
        logic [3:0]  volume_or_rate;
        logic        envelope_start;
        logic [3:0]  decay_level;
        logic [3:0]  envelope_count;
        logic        sweep_on;
        logic [2:0]  sweep_rate;
        logic        sweep_down;
        logic [2:0]  sweep_amount;
        logic [2:0]  sweep_count;
        logic        sweep_restart;
        logic        channel_on;
    } t_state;

    localparam t_state STATE_RESET = '{
        wave_shift:        WAVE_RESET,
        fixed_volume_mode: 1'b1,
        default:           '0
    };

endpackage

// File: rtl/square_wave_channel.sv
//  Channel   Direction  Handshake                 Beat contents
//  in        to block   i_in_valid / o_in_stall    action, reg_index, data_byte
//  out       from block o_out_valid / i_out_stall  level
//  cfg       to block   i_cfg_we                   i_cfg_index, i_cfg_data
//
// One beat is accepted per cycle unless o_in_stall; its level passes input and result registers.
// The rate is set by the single state-update pass between the input and result registers.
// Reset is synchronous and active low; no clearing pass is needed.
// An output stall holds the result register and then the input register, which raises o_in_stall.
//
// Top level of the square-wave channel; depends on sqch_pkg, sqch_cfg, sqch_core
// and square_wave_channel_assert.svh.
module square_wave_channel (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [2:0]                       i_in_action,
    input  logic [1:0]                       i_in_reg_index,
    input  logic [7:0]                       i_in_data_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [3:0]                       o_out_level,
    input  logic                             i_cfg_we,
    input  logic [sqch_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sqch_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sqch_pkg::*;

    `include "square_wave_channel_assert.svh"

    t_cfg       cfg;
    t_item      r_item;
    logic       r_in_valid;
    logic       n_in_valid;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [3:0] r_level;
    logic [3:0] level;
    logic       out_blocked;
    logic       in_accept;
    logic       advance;

    assign out_blocked = r_out_valid && i_out_stall;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign advance     = r_in_valid && !out_blocked;
    assign n_in_valid  = in_accept || (r_in_valid && out_blocked);
    assign n_out_valid = advance || out_blocked;

    sqch_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sqch_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_level (level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.action    <= t_action'(i_in_action);
            r_item.reg_index <= t_reg'(i_in_reg_index);
            r_item.data_byte <= i_in_data_byte;
        end
        if (advance) begin
            r_level <= level;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_level = r_level;

    // An accepted beat always occupies the input register in the next cycle.
    `SQCH_ASSERT_NEXT(a_accept_held, in_accept, r_in_valid, "accepted beat lost from input register")
    // A beat that leaves the input register always produces a result beat.
    `SQCH_ASSERT_NEXT(a_advance_result, advance, r_out_valid, "state update without result beat")

endmodule

// File: rtl/sqch_cfg.sv
// Configuration registers of the square-wave channel: duty patterns and negate mode.
// Depends on sqch_pkg.
module sqch_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sqch_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sqch_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sqch_pkg::t_cfg                   o_cfg
);
    import sqch_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty[0]     <= DUTY_0_RESET;
            r_cfg.duty[1]     <= DUTY_1_RESET;
            r_cfg.duty[2]     <= DUTY_2_RESET;
            r_cfg.duty[3]     <= DUTY_3_RESET;
            r_cfg.negate_ones <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DUTY_0: r_cfg.duty[0]     <= i_cfg_data;
                CFG_DUTY_1: r_cfg.duty[1]     <= i_cfg_data;
                CFG_DUTY_2: r_cfg.duty[2]     <= i_cfg_data;
                CFG_DUTY_3: r_cfg.duty[3]     <= i_cfg_data;
                CFG_NEGATE: r_cfg.negate_ones <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/sqch_core.sv
// Channel state and its single-pass update: register writes, timer, envelope, length, sweep, enable, level.
// Depends on sqch_pkg and square_wave_channel_assert.svh.
module sqch_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  sqch_pkg::t_item i_item,
    input  sqch_pkg::t_cfg  i_cfg,
    output logic [3:0]      o_level
);
    import sqch_pkg::*;

    `include "square_wave_channel_assert.svh"

    t_state      r_state;
    t_state      n_state;
    logic [11:0] cur_target;
    logic [11:0] nxt_target;
    logic        cur_mute;
    logic        nxt_mute;
    logic [1:0]  duty_sel;
    logic [7:0]  duty_bits;
    logic [7:0]  v;

    function automatic logic [11:0] sweep_target(input logic [10:0] p,
                                                 input logic [2:0]  amount,
                                                 input logic        down,
                                                 input logic        neg_ones);
        logic [11:0] change;
        logic [11:0] sub;
        change = {1'b0, p >> amount};
        if (down) begin
            sub = change + {11'd0, neg_ones};
            sweep_target = (sub > {1'b0, p}) ? 12'd0 : ({1'b0, p} - sub);
        end else begin
            sweep_target = {1'b0, p} + change;
        end
    endfunction

    assign v = i_item.data_byte;
    assign cur_target = sweep_target(r_state.period, r_state.sweep_amount,
                                     r_state.sweep_down, i_cfg.negate_ones);
    assign cur_mute   = (r_state.period < PERIOD_MIN) || cur_target[11];

    assign duty_sel  = (i_item.reg_index == REG_CTRL) ? v[7:6] : r_state.duty_select;
    assign duty_bits = i_cfg.duty[duty_sel];

    always_comb begin
        n_state = r_state;
        case (i_item.action)
            ACT_REG_WRITE: begin
                case (i_item.reg_index)
                    REG_CTRL: begin
                        n_state.duty_select       = v[7:6];
                        n_state.wave_shift        = duty_bits;
                        n_state.length_halt       = v[5];
                        n_state.fixed_volume_mode = v[4];
                        n_state.volume_or_rate    = v[3:0];
                    end
                    REG_SWEEP: begin
                        n_state.sweep_on      = v[7];
                        n_state.sweep_rate    = v[6:4];
                        n_state.sweep_down    = v[3];
                        n_state.sweep_amount  = v[2:0];
                        n_state.sweep_restart = 1'b1;
                    end
                    REG_PERIOD_LO: begin
                        n_state.period = {r_state.period[10:8], v};
                    end
                    REG_PERIOD_HI: begin
                        n_state.period = {v[2:0], r_state.period[7:0]};
                        if (r_state.channel_on) begin
                            n_state.length_left = LEN_TABLE[v[7:3]];
                        end
                        n_state.envelope_start = 1'b1;
                        n_state.countdown      = {v[2:0], r_state.period[7:0]};
                        n_state.wave_shift     = duty_bits;
                    end
                    default: begin
                    end
                endcase
            end
            ACT_TIMER: begin
                if (r_state.countdown == 11'd0) begin
                    n_state.countdown  = r_state.period;
                    n_state.wave_shift = {r_state.wave_shift[6:0], r_state.wave_shift[7]};
                end else begin
                    n_state.countdown = r_state.countdown - 11'd1;
                end
            end
            ACT_QUARTER: begin
                if (r_state.envelope_start) begin
                    n_state.envelope_start = 1'b0;
                    n_state.decay_level    = FULL_DECAY;
                    n_state.envelope_count = r_state.volume_or_rate;
                end else if (r_state.envelope_count == 4'd0) begin
                    n_state.envelope_count = r_state.volume_or_rate;
                    if (r_state.decay_level != 4'd0) begin
                        n_state.decay_level = r_state.decay_level - 4'd1;
                    end else if (r_state.length_halt) begin
                        n_state.decay_level = FULL_DECAY;
                    end
                end else begin
                    n_state.envelope_count = r_state.envelope_count - 4'd1;
                end
            end
            ACT_HALF: begin
                if (r_state.length_left != 8'd0 && !r_state.length_halt) begin
                    n_state.length_left = r_state.length_left - 8'd1;
                end
                if (r_state.sweep_count == 3'd0 && r_state.sweep_on &&
                    r_state.sweep_amount != 3'd0 && !cur_mute) begin
                    n_state.period = cur_target[10:0];
                end
                if (r_state.sweep_count == 3'd0 || r_state.sweep_restart) begin
                    n_state.sweep_count   = r_state.sweep_rate;
                    n_state.sweep_restart = 1'b0;
                end else begin
                    n_state.sweep_count = r_state.sweep_count - 3'd1;
                end
            end
            ACT_ENABLE: begin
                n_state.channel_on = v[0];
                if (!v[0]) begin
                    n_state.length_left = 8'd0;
                end
            end
            default: begin
            end
        endcase
    end

    assign nxt_target = sweep_target(n_state.period, n_state.sweep_amount,
                                     n_state.sweep_down, i_cfg.negate_ones);
    assign nxt_mute   = (n_state.period < PERIOD_MIN) || nxt_target[11];

    always_comb begin
        if (nxt_mute || n_state.length_left == 8'd0 || !n_state.channel_on ||
            !n_state.wave_shift[7]) begin
            o_level = 4'd0;
        end else if (n_state.fixed_volume_mode) begin
            o_level = n_state.volume_or_rate;
        end else begin
            o_level = n_state.decay_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    // A disabled channel never holds a nonzero length count.
    `SQCH_ASSERT_NOW(a_off_no_length, !r_state.channel_on, r_state.length_left == 8'd0, "length count nonzero while channel disabled")
    // A period-high write always arms the envelope restart.
    `SQCH_ASSERT_NEXT(a_env_armed, i_step && i_item.action == ACT_REG_WRITE && i_item.reg_index == REG_PERIOD_HI, r_state.envelope_start, "envelope restart not armed after period-high write")

endmodule
